// File: design/rlh_pkg.sv
`default_nettype none
package rlh_pkg;

   localparam int BIN_COUNT          = 256;
   localparam int BIN_BITS           = 8;
   localparam int CHAN_COUNT         = 4;
   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int REPORT_BITS        = 32;
   localparam int WIDE_BITS          = 64;
   localparam int QUEUE_DEPTH        = 4;
   localparam int CMD_BITS           = 2;
   localparam int PIX_BITS           = 8;

   localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

   // channel order in the bin banks and in the result word
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_LUMA  = 3;

   // luma = (299r + 587g + 114b) / 1000; the sum stays below 2^18 and the
   // reciprocal 2^28/1000 rounded up is exact for every sum below 493447
   localparam int LUMA_SUM_BITS   = 18;
   localparam int LUMA_RECIP_BITS = 19;
   localparam int LUMA_SHIFT      = 28;
   localparam int LUMA_PROD_BITS  = LUMA_SUM_BITS + LUMA_RECIP_BITS;
   localparam logic [LUMA_SUM_BITS-1:0]   LUMA_WR    = 18'd299;
   localparam logic [LUMA_SUM_BITS-1:0]   LUMA_WG    = 18'd587;
   localparam logic [LUMA_SUM_BITS-1:0]   LUMA_WB    = 18'd114;
   localparam logic [LUMA_RECIP_BITS-1:0] LUMA_RECIP = 19'd268436;

   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
      logic [PIX_BITS-1:0] luma;
      logic [BIN_BITS-1:0] bin_index;
   } rlh_item_type;

   // clamp a count to the 32-bit result field
   function automatic logic [REPORT_BITS-1:0] rlh_report(input logic [WIDE_BITS-1:0] c);
      logic [REPORT_BITS-1:0] r;
      r = (|c[WIDE_BITS-1:REPORT_BITS]) ? '1 : c[REPORT_BITS-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/rlh_front.sv
`default_nettype none
module rlh_front
   import rlh_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [CMD_BITS-1:0] req_tuser,
   input  wire logic [31:0]         req_tdata,
   input  wire logic                csr_wen,
   input  wire logic                csr_wdata,
   input  wire logic                bins_ready,
   input  wire logic                q_full,
   output logic                     q_push,
   output rlh_item_type             q_item
);

   logic                     blue_present_ff, blue_present_in;
   logic                     s1_valid_ff, s1_valid_in;
   rlh_item_type             s1_item_ff, s1_item_in;
   logic [LUMA_SUM_BITS-1:0] sum_ff, sum_in;
   logic [LUMA_PROD_BITS-1:0] prod;
   logic                     accept;
   logic [PIX_BITS-1:0]      red, green, blue;

   assign red   = req_tdata[7:0];
   assign green = req_tdata[15:8];
   assign blue  = blue_present_ff ? req_tdata[23:16] : req_tdata[15:8];

   assign req_tready = bins_ready && (!s1_valid_ff || !q_full);
   assign accept     = req_tvalid && req_tready;
   assign q_push     = s1_valid_ff && !q_full;

   always_comb begin
      blue_present_in = csr_wen ? csr_wdata : blue_present_ff;
      s1_valid_in     = accept || (s1_valid_ff && !q_push);
      s1_item_in      = s1_item_ff;
      sum_in          = sum_ff;
      if (accept) begin
         s1_item_in.cmd       = req_tuser;
         s1_item_in.red       = red;
         s1_item_in.green     = green;
         s1_item_in.blue      = blue;
         s1_item_in.luma      = '0;
         s1_item_in.bin_index = req_tdata[31:24];
         sum_in = LUMA_WR * LUMA_SUM_BITS'(red) + LUMA_WG * LUMA_SUM_BITS'(green)
                + LUMA_WB * LUMA_SUM_BITS'(blue);
      end
   end

   // divide by 1000 through the reciprocal
   assign prod = LUMA_PROD_BITS'(sum_ff) * LUMA_PROD_BITS'(LUMA_RECIP);

   always_comb begin
      q_item      = s1_item_ff;
      q_item.luma = prod[LUMA_SHIFT +: PIX_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blue_present_ff <= 1'b1;
         s1_valid_ff     <= 1'b0;
      end else begin
         blue_present_ff <= blue_present_in;
         s1_valid_ff     <= s1_valid_in;
      end
      s1_item_ff <= s1_item_in;
      sum_ff     <= sum_in;
   end

endmodule
`default_nettype wire

// File: design/rlh_queue.sv
`default_nettype none
module rlh_queue
   import rlh_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire rlh_item_type push_item,
   output logic        full,
   input  wire logic   pop,
   output rlh_item_type head_item,
   output logic        empty
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   rlh_item_type        entries [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full      = (fill_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty     = (fill_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// File: design/rlh_back.sv
`default_nettype none
module rlh_back
   import rlh_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_empty,
   input  wire rlh_item_type q_item,
   output logic             q_pop,
   output logic             bins_ready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [5*REPORT_BITS-1:0] rsp_tdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ACC   = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [1:0]             state_ff, state_in;
   rlh_item_type           cur_ff, cur_in;
   logic [BIN_BITS-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                   init_done_ff, init_done_in;
   logic [COUNT_BITS-1:0]  pixel_ff, pixel_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [5*REPORT_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [COUNT_BITS-1:0]  rd_data_ff [CHAN_COUNT];
   logic [BIN_BITS-1:0]    rd_addr    [CHAN_COUNT];
   logic [BIN_BITS-1:0]    wr_addr    [CHAN_COUNT];
   logic [COUNT_BITS-1:0]  wr_data    [CHAN_COUNT];
   logic [BIN_BITS-1:0]    head_addr  [CHAN_COUNT];
   logic [BIN_BITS-1:0]    cur_addr   [CHAN_COUNT];
   logic                   wr_en;
   logic                   head_is_add;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      r = (&v) ? v : v + COUNT_BITS'(1);
      return r;
   endfunction

   assign head_addr[CH_RED]   = q_item.red;
   assign head_addr[CH_GREEN] = q_item.green;
   assign head_addr[CH_BLUE]  = q_item.blue;
   assign head_addr[CH_LUMA]  = q_item.luma;
   assign cur_addr[CH_RED]    = cur_ff.red;
   assign cur_addr[CH_GREEN]  = cur_ff.green;
   assign cur_addr[CH_BLUE]   = cur_ff.blue;
   assign cur_addr[CH_LUMA]   = cur_ff.luma;

   assign head_is_add = (q_item.cmd == CMD_ADD);
   // a read waits for the result register to drain
   assign q_pop = (state_ff == ST_IDLE) && !q_empty
                  && ((q_item.cmd != CMD_READ) || !rsp_valid_ff);
   assign wr_en = (state_ff == ST_CLEAR) || ((state_ff == ST_ACC) && (cur_ff.cmd == CMD_ADD));

   always_comb begin
      for (int ch = 0; ch < CHAN_COUNT; ch++) begin
         rd_addr[ch] = head_is_add ? head_addr[ch] : q_item.bin_index;
         wr_addr[ch] = (state_ff == ST_CLEAR) ? clr_cnt_ff : cur_addr[ch];
         wr_data[ch] = (state_ff == ST_CLEAR) ? '0 : sat_inc(rd_data_ff[ch]);
      end
   end

   for (genvar ch = 0; ch < CHAN_COUNT; ch++) begin : g_bank
      logic [COUNT_BITS-1:0] bin_mem [BIN_COUNT];
      always_ff @(posedge clock) begin
         if (wr_en) begin
            bin_mem[wr_addr[ch]] <= wr_data[ch];
         end
         rd_data_ff[ch] <= bin_mem[rd_addr[ch]];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      clr_cnt_in   = clr_cnt_ff;
      init_done_in = init_done_ff;
      pixel_in     = pixel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               cur_in = q_item;
               case (q_item.cmd)
                  CMD_ADD, CMD_READ: state_in = ST_ACC;
                  CMD_CLEAR: begin
                     state_in   = ST_CLEAR;
                     clr_cnt_in = '0;
                     pixel_in   = '0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACC: begin
            state_in = ST_IDLE;
            if (cur_ff.cmd == CMD_ADD) begin
               pixel_in = sat_inc(pixel_ff);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rlh_report(WIDE_BITS'(pixel_ff)),
                               rlh_report(WIDE_BITS'(rd_data_ff[CH_LUMA])),
                               rlh_report(WIDE_BITS'(rd_data_ff[CH_BLUE])),
                               rlh_report(WIDE_BITS'(rd_data_ff[CH_GREEN])),
                               rlh_report(WIDE_BITS'(rd_data_ff[CH_RED]))};
            end
         end
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == BIN_BITS'(BIN_COUNT - 1)) begin
               state_in     = ST_IDLE;
               init_done_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         init_done_ff <= 1'b0;
         pixel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         init_done_ff <= init_done_in;
         pixel_ff     <= pixel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign bins_ready = init_done_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: design/rgb_luma_histogram.sv
// Red, green, blue and luma histograms of 256 bins each, fed by a command
// stream.
// req channel: tuser carries the command (add pixel, read bin, clear all);
// tdata carries red, green, blue and the bin number. An add counts the pixel
// in all four histograms and in the pixel total; when csr blue_present is 0
// the green value stands in for blue. A read gives one transfer on the rsp
// channel with the four counts of that bin and the pixel total. Counters
// saturate; counts wider than 32 bits clamp on the way out.
// One add or read occupies the bin banks for a registered read, then an
// increment and write back; the banks take the next item only after that
// write back. With the banks idle, a read passes the front-end register, the
// queue, the bin bank read and the result register before rsp_tvalid rises.
// A clear walks the 256 bin addresses, one per cycle.
// A 4-entry queue between the pixel front end and the bin banks keeps taking
// items while the banks are busy, up to its depth.
// Reset: blue_present returns to 1 and a clearing pass zeroes all 256 bins;
// req_tready stays low until it ends. csr writes are taken at any time.
// A stalled rsp holds its result; further reads wait behind it in the queue.
`default_nettype none
module rgb_luma_histogram
   import rlh_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [CMD_BITS-1:0]     req_tuser,  // cmd
   input  wire logic [31:0]             req_tdata,  // red, green, blue, bin_index
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // red_count, green_count, blue_count, luma_count, pixel_total
   output logic [5*REPORT_BITS-1:0]     rsp_tdata,
   input  wire logic                    csr_wen,
   input  wire logic                    csr_wdata
);

   logic         q_push, q_full, q_pop, q_empty, bins_ready;
   rlh_item_type push_item, head_item;

   rlh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .bins_ready (bins_ready),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   rlh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (head_item),
      .empty     (q_empty)
   );

   rlh_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .bins_ready (bins_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
